// ----- src/srfir_pkg.sv -----
package srfir_pkg;

  localparam int SampleBits = 16;
  localparam int ResBits    = 18;
  localparam int HistDepth  = 4;
  localparam int WinDepth   = HistDepth + 1;
  localparam int PosBits    = 3;
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);

  // difference 18*x minus four neighbor terms, at most 48 * 2^(SampleBits-1) in magnitude
  localparam int DiffBits  = SampleBits + 7;
  // difference clamped to this width keeps saturation exact
  localparam int ClampBits = 24;
  localparam int DExtBits  = (DiffBits > ClampBits) ? DiffBits : ClampBits;

  // floor((d + 17) / 35) on an offset, nonnegative value by reciprocal multiply
  localparam int MBits    = 29;
  localparam int MulBits  = 30;
  localparam int ProdBits = MBits + MulBits;
  localparam int DivShift = 35;
  localparam int QuoBits  = ProdBits - DivShift;

  localparam logic [MulBits-1:0] DivMul  = 30'd981706811;
  localparam logic [MBits-1:0]   MOffset = MBits'(35 * (1 << (ClampBits - 1)) + 17);

  typedef logic signed [SampleBits-1:0] sample_t;

  typedef struct packed {
    logic signed [SampleBits-1:0] sample;
    logic                         first_of_frame;
    logic                         last_of_frame;
  } srfir_in_t;

  typedef struct packed {
    logic signed [ResBits-1:0] residual;
    logic                      last_result;
  } srfir_out_t;

  typedef struct packed {
    sample_t [WinDepth-1:0] win;
    logic [PosBits-1:0]     pos;
    logic [1:0]             kstart;
    logic                   last;
  } srfir_entry_t;

  typedef struct packed {
    logic         wr;
    srfir_entry_t entry;
  } srfir_qwr_t;

  typedef struct packed {
    logic empty;
    logic full;
  } srfir_qstat_t;

endpackage

// ----- src/srfir_front.sv -----
module srfir_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  srfir_pkg::srfir_in_t   in_data_i,
  input  srfir_pkg::srfir_qstat_t qstat_i,
  output logic                   full_o,
  output srfir_pkg::srfir_qwr_t  qwr_o
);
  import srfir_pkg::*;

  sample_t            hist_q [HistDepth];
  logic [1:0]         pos_q;
  logic               open_q;
  logic               accept;
  logic [PosBits-1:0] p;
  logic               has_result;

  always_comb begin
    accept = push_i && !qstat_i.full;
    if (in_data_i.first_of_frame || !open_q) begin
      p = '0;
    end else begin
      p = PosBits'(pos_q) + PosBits'(1);
    end
    has_result = in_data_i.last_of_frame || (p >= PosBits'(2));

    qwr_o.entry.win[0] = in_data_i.sample;
    for (int i = 0; i < HistDepth; i++) begin
      qwr_o.entry.win[i+1] = hist_q[i];
    end
    qwr_o.entry.pos  = p;
    qwr_o.entry.last = in_data_i.last_of_frame;
    if (in_data_i.last_of_frame && (p < PosBits'(2))) begin
      qwr_o.entry.kstart = p[1:0];
    end else begin
      qwr_o.entry.kstart = 2'd2;
    end
    qwr_o.wr = accept && has_result;
    full_o   = qstat_i.full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) begin
        hist_q[i] <= '0;
      end
      pos_q  <= '0;
      open_q <= 1'b0;
    end else if (accept) begin
      hist_q[0] <= in_data_i.sample;
      for (int i = 1; i < HistDepth; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
      if (in_data_i.last_of_frame) begin
        pos_q  <= '0;
        open_q <= 1'b0;
      end else begin
        pos_q  <= (p > PosBits'(3)) ? 2'd3 : p[1:0];
        open_q <= 1'b1;
      end
    end
  end

endmodule

// ----- src/srfir_queue.sv -----
module srfir_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srfir_pkg::srfir_qwr_t   qwr_i,
  input  logic                    rd_i,
  output srfir_pkg::srfir_entry_t head_o,
  output srfir_pkg::srfir_qstat_t stat_o
);
  import srfir_pkg::*;

  srfir_entry_t        mem_q [QueueDepth];
  logic [QPtrBits-1:0] wptr_q;
  logic [QPtrBits-1:0] rptr_q;
  logic [QPtrBits:0]   cnt_q;
  logic                do_wr;
  logic                do_rd;

  always_comb begin
    stat_o.empty = (cnt_q == '0);
    stat_o.full  = (cnt_q == (QPtrBits+1)'(QueueDepth));
    do_wr        = qwr_i.wr && !stat_o.full;
    do_rd        = rd_i && !stat_o.empty;
    head_o       = mem_q[rptr_q];
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= qwr_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) begin
        wptr_q <= wptr_q + QPtrBits'(1);
      end
      if (do_rd) begin
        rptr_q <= rptr_q + QPtrBits'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + (QPtrBits+1)'(1);
        2'b01:   cnt_q <= cnt_q - (QPtrBits+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ----- src/srfir_back.sv -----
module srfir_back (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  srfir_pkg::srfir_entry_t head_i,
  input  logic                    head_valid_i,
  output logic                    rd_o,
  input  logic                    pop_i,
  output logic                    empty_o,
  output srfir_pkg::srfir_out_t   out_data_o
);
  import srfir_pkg::*;

  localparam logic signed [DiffBits-1:0]  WEdge   = DiffBits'(-3);
  localparam logic signed [DiffBits-1:0]  WNear   = DiffBits'(12);
  localparam logic signed [DiffBits-1:0]  WCentre = DiffBits'(18);
  localparam logic signed [DExtBits-1:0]  DMax    = DExtBits'((1 << (ClampBits - 1)) - 1);
  localparam logic signed [DExtBits-1:0]  DMin    = -DExtBits'(1 << (ClampBits - 1));
  localparam logic signed [QuoBits:0]     QuoBias = (QuoBits+1)'(1 << (ClampBits - 1));
  localparam logic signed [QuoBits:0]     ResMax  = (QuoBits+1)'((1 << (ResBits - 1)) - 1);
  localparam logic signed [QuoBits:0]     ResMin  = -(QuoBits+1)'(1 << (ResBits - 1));

  logic                         en;
  logic                         issue;
  logic                         done_entry;
  logic [1:0]                   k;
  logic [1:0]                   k_q;
  logic                         busy_q;

  sample_t                      xs, wa, wb, wc, wd;
  logic                         va, vb, vc, vd;
  logic signed [DiffBits-1:0]   xe, ta, tb, tc, td, diff;
  logic signed [DExtBits-1:0]   dx;
  logic signed [ClampBits-1:0]  dc;
  logic [MBits-1:0]             m_d;

  logic                         a_v_q;
  logic                         a_last_q;
  logic [MBits-1:0]             a_m_q;
  logic                         b_v_q;
  logic                         b_last_q;
  logic [ProdBits-1:0]          b_prod_q;
  logic [QuoBits-1:0]           quo;
  logic signed [QuoBits:0]      res_w;
  logic signed [ResBits-1:0]    res_sat;
  logic                         out_v_q;
  srfir_out_t                   out_q;

  always_comb begin
    en         = !out_v_q || pop_i;
    issue      = en && head_valid_i;
    k          = busy_q ? k_q : head_i.kstart;
    done_entry = !head_i.last || (k == 2'd0);
    rd_o       = issue && done_entry;
  end

  // window taps around the center offset k
  always_comb begin
    case (k)
      2'd0: begin
        xs = head_i.win[0]; wa = head_i.win[2]; wb = head_i.win[1];
        wc = head_i.win[0]; wd = head_i.win[0];
        va = (head_i.pos >= PosBits'(2)); vb = (head_i.pos >= PosBits'(1));
        vc = 1'b0; vd = 1'b0;
      end
      2'd1: begin
        xs = head_i.win[1]; wa = head_i.win[3]; wb = head_i.win[2];
        wc = head_i.win[0]; wd = head_i.win[0];
        va = (head_i.pos >= PosBits'(3)); vb = (head_i.pos >= PosBits'(2));
        vc = 1'b1; vd = 1'b0;
      end
      default: begin
        xs = head_i.win[2]; wa = head_i.win[4]; wb = head_i.win[3];
        wc = head_i.win[1]; wd = head_i.win[0];
        va = (head_i.pos >= PosBits'(4)); vb = (head_i.pos >= PosBits'(3));
        vc = 1'b1; vd = 1'b1;
      end
    endcase

    xe   = DiffBits'(xs);
    ta   = va ? WEdge * DiffBits'(wa) : xe;
    tb   = vb ? WNear * DiffBits'(wb) : xe;
    tc   = vc ? WNear * DiffBits'(wc) : xe;
    td   = vd ? WEdge * DiffBits'(wd) : xe;
    diff = WCentre * xe - ta - tb - tc - td;

    dx = DExtBits'(diff);
    if (dx > DMax) begin
      dx = DMax;
    end else if (dx < DMin) begin
      dx = DMin;
    end
    dc  = dx[ClampBits-1:0];
    m_d = MBits'(dc) + MOffset;
  end

  always_comb begin
    quo   = b_prod_q[ProdBits-1:DivShift];
    res_w = $signed({1'b0, quo}) - QuoBias;
    if (res_w > ResMax) begin
      res_sat = ResMax[ResBits-1:0];
    end else if (res_w < ResMin) begin
      res_sat = ResMin[ResBits-1:0];
    end else begin
      res_sat = res_w[ResBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      k_q     <= '0;
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      if (issue) begin
        busy_q <= !done_entry;
        k_q    <= k - 2'd1;
      end
      a_v_q   <= issue;
      b_v_q   <= a_v_q;
      out_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_m_q             <= m_d;
      a_last_q          <= head_i.last && (k == 2'd0);
      b_prod_q          <= ProdBits'(a_m_q) * ProdBits'(DivMul);
      b_last_q          <= a_last_q;
      out_q.residual    <= res_sat;
      out_q.last_result <= b_last_q;
    end
  end

  assign empty_o    = !out_v_q;
  assign out_data_o = out_q;

endmodule

// ----- src/savgol_residual_fir5_core.sv -----
// Five-point quadratic smoothing residual over framed sample streams.
// Input queue side: drive in_data_i and push; the sample transfers on a clock
// edge with push high and full low. first_of_frame starts a frame,
// last_of_frame ends it and flushes the pending residuals.
// Output queue side: while empty is low the oldest residual is on out_data_o;
// it transfers on a clock edge with pop high. last_result marks the residual
// of the frame's final sample.
// Throughput: one sample per cycle while full is low. Residuals lag two
// samples within a frame; a final sample yields up to three residuals in
// turn, buffered in a four-entry queue between the front end and the
// arithmetic pipeline. A residual passes the queue read, weighted sum,
// reciprocal multiply, and rounding and saturation in the output register.
// Reset clears the sample history, closes any open frame and empties the
// queue and pipeline. When the receiver stalls, the pipeline holds, the queue
// fills and full rises; no residual is lost.
module savgol_residual_fir5_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  srfir_pkg::srfir_in_t  in_data_i,
  output logic                  empty,
  input  logic                  pop,
  output srfir_pkg::srfir_out_t out_data_o
);
  import srfir_pkg::*;

  srfir_qwr_t   qwr;
  srfir_qstat_t qstat;
  srfir_entry_t head;
  logic         back_rd;
  logic         push_acc;

  srfir_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .in_data_i (in_data_i),
    .qstat_i   (qstat),
    .full_o    (full),
    .qwr_o     (qwr)
  );

  srfir_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .qwr_i  (qwr),
    .rd_i   (back_rd),
    .head_o (head),
    .stat_o (qstat)
  );

  srfir_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (!qstat.empty),
    .rd_o         (back_rd),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_data_o   (out_data_o)
  );

  assign push_acc = push && !full;

  // a frame end always leaves work in the queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_acc && in_data_i.last_of_frame) |=> !qstat.empty)
    else $error("frame end transfer left no queue entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    back_rd |-> !qstat.empty)
    else $error("back end read from an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !qstat.empty)
    else $error("full raised with an empty queue");

endmodule

// ----- sim/srfir_residual_checker.sv -----
module srfir_residual_checker (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic                  full_i,
  input  srfir_pkg::srfir_in_t  in_data_i,
  input  logic                  empty_i,
  input  logic                  pop_i,
  input  srfir_pkg::srfir_out_t out_data_i,
  output int                    mismatches_o,
  output int                    pending_o
);
  import srfir_pkg::*;

  localparam longint ResMax = (longint'(1) << (ResBits - 1)) - 1;
  localparam longint ResMin = -(longint'(1) << (ResBits - 1));

  sample_t    history [HistDepth];
  int         frame_pos;
  logic       frame_open;
  longint     window [WinDepth];
  int         fail_count;
  srfir_out_t expected_residuals [$];

  // window[0] is the newest sample; p is the oldest offset still in the frame
  function automatic logic [ResBits-1:0] centre_residual(int p, int k);
    longint x, s, num, r, tap;
    int     t, o;
    x = window[k];
    s = 0;
    for (t = 0; t < 5; t++) begin
      o = k + 2 - t;
      tap = (t == 0 || t == 4) ? -3 : 12;
      if (t == 2) begin
        s += 17 * x;
      end else if (o >= 0 && o <= p && o < WinDepth) begin
        s += tap * window[o];
      end else begin
        s += x;
      end
    end
    num = 2 * (35 * x - s) + 35;
    r = (num >= 0) ? num / 70 : -((69 - num) / 70);
    if (r > ResMax) r = ResMax;
    if (r < ResMin) r = ResMin;
    return r[ResBits-1:0];
  endfunction

  task automatic predict_residuals(srfir_in_t item);
    int         p, k;
    srfir_out_t res;
    p = (item.first_of_frame || !frame_open) ? 0 : frame_pos + 1;
    window[0] = item.sample;
    for (k = 0; k < HistDepth; k++) window[k+1] = history[k];
    if (item.last_of_frame) begin
      for (k = 2; k >= 0; k--) begin
        if (p >= k) begin
          res.residual    = centre_residual(p, k);
          res.last_result = (k == 0);
          expected_residuals.push_back(res);
        end
      end
    end else if (p >= 2) begin
      res.residual    = centre_residual(p, 2);
      res.last_result = 1'b0;
      expected_residuals.push_back(res);
    end
    for (k = HistDepth - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = item.sample;
    if (item.last_of_frame) begin
      frame_open = 1'b0;
      frame_pos  = 0;
    end else begin
      frame_open = 1'b1;
      frame_pos  = (p > 3) ? 3 : p;
    end
  endtask

  task automatic check_residual(srfir_out_t got);
    srfir_out_t want;
    if (expected_residuals.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected residual %0d last %0b", got.residual, got.last_result);
    end else begin
      want = expected_residuals.pop_front();
      if (got.residual !== want.residual || got.last_result !== want.last_result) begin
        fail_count++;
        if (fail_count <= 10)
          $display("residual: expected %0d last %0b, got %0d last %0b",
                   want.residual, want.last_result, got.residual, got.last_result);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (history[i]) history[i] = '0;
      frame_pos  = 0;
      frame_open = 1'b0;
      expected_residuals.delete();
      fail_count = 0;
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      // output transfer first: a new sample cannot complete a residual in the same cycle
      if (pop_i && !empty_i) check_residual(out_data_i);
      if (push_i && !full_i) predict_residuals(in_data_i);
      mismatches_o <= fail_count;
      pending_o    <= expected_residuals.size();
    end
  end

endmodule

// ----- sim/tb.sv -----
module tb;
  import srfir_pkg::*;

  localparam sample_t SampleMax = {1'b0, {(SampleBits - 1){1'b1}}};
  localparam sample_t SampleMin = {1'b1, {(SampleBits - 1){1'b0}}};
  localparam int      StallLimit = 2000;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic       empty;
  logic       pop;
  srfir_in_t  in_data;
  srfir_out_t out_data;
  int         mismatches;
  int         pending;
  int         stall_cycles;
  int         sent;
  int         popped;
  bit         in_burst;
  bit         out_burst;

  savgol_residual_fir5_core dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data)
  );

  srfir_residual_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .push_i       (push),
    .full_i       (full),
    .in_data_i    (in_data),
    .empty_i      (empty),
    .pop_i        (pop),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int draw_gap(ref bit burst);
    if ($urandom_range(0, 15) == 0) burst = ~burst;
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic sample_t draw_sample();
    case ($urandom_range(0, 7))
      0: return SampleMax;
      1: return SampleMin;
      2: return sample_t'($urandom_range(0, 8)) - sample_t'(4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge
  task automatic send_sample(sample_t s, logic first, logic last);
    int gap;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      push = 1'b0;
      repeat (gap) @(negedge clk);
    end
    push = 1'b1;
    in_data.sample         = s;
    in_data.first_of_frame = first;
    in_data.last_of_frame  = last;
    do @(posedge clk); while (full);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(int len, bit with_first, bit with_last);
    int i;
    for (i = 0; i < len; i++)
      send_sample(draw_sample(), with_first && i == 0, with_last && i == len - 1);
  endtask

  initial begin
    int len;
    rst_n   = 1'b0;
    push    = 1'b0;
    in_data = '0;
    sent    = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // one-sample frames
    send_sample(SampleMax, 1'b1, 1'b1);
    send_sample(SampleMin, 1'b1, 1'b1);
    // two- and three-sample frames
    send_sample(SampleMin, 1'b1, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b1);
    send_sample(SampleMax, 1'b1, 1'b0);
    send_sample(SampleMin, 1'b0, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b1);
    // frame opened without a first flag, alternating extremes
    send_sample(SampleMin, 1'b0, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b0);
    send_sample(SampleMin, 1'b0, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b0);
    send_sample(SampleMin, 1'b0, 1'b0);
    send_sample(SampleMax, 1'b0, 1'b1);
    // open frame cut short by a new first flag
    send_sample(16'sd100, 1'b1, 1'b0);
    send_sample(-16'sd5, 1'b0, 1'b0);
    send_sample(16'sd7, 1'b0, 1'b0);
    send_sample(16'sd0, 1'b1, 1'b0);
    send_sample(-16'sd1, 1'b0, 1'b0);
    send_sample(16'sd1, 1'b0, 1'b0);
    send_sample(16'sd0, 1'b0, 1'b1);
    // lone last flag with no frame open
    send_sample(-16'sd1, 1'b0, 1'b1);

    while (sent < 380) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      case ($urandom_range(0, 9))
        0: send_frame(len, 1'b0, 1'b1);
        1: send_frame(len, 1'b1, 1'b0);
        default: send_frame(len, 1'b1, 1'b1);
      endcase
    end
    send_frame(3, 1'b1, 1'b1);
    push = 1'b0;

    wait (pending == 0);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    int gap;
    pop    = 1'b0;
    popped = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      gap = draw_gap(out_burst);
      // long hold-off so the queue fills and the input stalls
      if (popped == 60 || popped == 240) gap = 80;
      if (gap > 0) begin
        pop = 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop = 1'b1;
      do @(posedge clk); while (empty);
      popped++;
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

// ----- filelist.f -----
src/srfir_pkg.sv
src/srfir_front.sv
src/srfir_queue.sv
src/srfir_back.sv
src/savgol_residual_fir5_core.sv
sim/srfir_residual_checker.sv
sim/tb.sv
